FILE: src/rfks_pkg.sv
// Package for the range-filtered k-nearest-neighbor scan.
// Holds sizes, command codes and the front-to-back request type; no dependencies.
`default_nettype none
package rfks_pkg;
	localparam int DIM_MAX = 128;
	localparam int K_MAX = 16;
	localparam int DIM_W = $clog2(DIM_MAX);
	localparam int K_W = $clog2(K_MAX);
	localparam int KCNT_W = $clog2(K_MAX + 1);
	localparam int DIST_W = 42;
	localparam int KEY_W = 32;
	localparam int VAL_W = 16;

	localparam logic [1:0] CMD_QUERY = 2'd0;
	localparam logic [1:0] CMD_POINT = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic [1:0] REG_KEY_LOW = 2'd0;
	localparam logic [1:0] REG_KEY_HIGH = 2'd1;
	localparam logic [1:0] REG_NCOUNT = 2'd2;
	localparam logic [1:0] REG_VLEN = 2'd3;

	// Request from front to back: offer a finished point, or finish and emit.
	typedef struct packed {
		logic finish;
		logic [DIST_W-1:0] sqdist;
		logic signed [KEY_W-1:0] key;
	} req_t;
endpackage
`default_nettype wire

FILE: src/rfks_front.sv
// Front part: query store, per-element squared-difference accumulation, key range test.
// Depends on rfks_pkg; pushes point offers and finish requests into the queue.
`default_nettype none
module rfks_front
	import rfks_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	input  wire logic [1:0] cmd,
	input  wire logic signed [VAL_W-1:0] element_value,
	input  wire logic signed [KEY_W-1:0] point_key,
	input  wire logic signed [KEY_W-1:0] key_low,
	input  wire logic signed [KEY_W-1:0] key_high,
	input  wire logic [DIM_W:0] eff_len,
	output logic push,
	output req_t push_req,
	input  wire logic q_ready
);
	logic [VAL_W-1:0] query_mem [DIM_MAX];
	logic [DIM_W:0] idx_q;
	logic [DIM_W-1:0] idx;
	logic [DIST_W-1:0] acc_q;
	// stage 1 registers
	logic v_s1, last_s1, fin_s1;
	logic signed [VAL_W-1:0] val_s1;
	logic signed [KEY_W-1:0] key_s1;
	logic [VAL_W-1:0] qv_s1;
	// stage 2 registers
	logic v_s2, last_s2;
	logic [33:0] sq_s2;
	logic signed [KEY_W-1:0] key_s2;
	logic signed [VAL_W:0] diff;
	logic [VAL_W:0] ad;
	logic [DIM_W:0] nxt;
	logic [DIST_W-1:0] acc_sum;
	logic acc_v;
	logic pipe_busy;

	assign pipe_busy = v_s1 | v_s2 | fin_s1;
	// Finish waits for in-flight point math and a free queue slot.
	assign in_ready = q_ready & !pipe_busy | (cmd != CMD_FINISH) & q_ready;
	assign idx = (idx_q >= eff_len) ? '0 : idx_q[DIM_W-1:0];
	assign nxt = {1'b0, idx} + 1'b1;

	wire acc = in_valid & in_ready;

	// Element index and query store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (acc) begin
			if (cmd == CMD_QUERY || cmd == CMD_POINT)
				idx_q <= (nxt >= eff_len) ? '0 : nxt;
			else if (cmd == CMD_FINISH)
				idx_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && cmd == CMD_QUERY) query_mem[idx] <= element_value;
		qv_s1 <= query_mem[idx];
		val_s1 <= element_value;
		key_s1 <= point_key;
		last_s1 <= nxt >= eff_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			fin_s1 <= 1'b0;
		end else begin
			v_s1 <= acc && cmd == CMD_POINT;
			fin_s1 <= acc && cmd == CMD_FINISH;
		end
	end

	// Squared difference, both operands sign-extended to 17 bits
	assign diff = {val_s1[VAL_W-1], val_s1} - {qv_s1[VAL_W-1], qv_s1};
	assign ad = diff[VAL_W] ? (VAL_W+1)'(0) - diff : diff;
	always_ff @(posedge clk) begin
		sq_s2 <= 34'(ad) * 34'(ad);
		key_s2 <= key_s1;
		last_s2 <= last_s1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1;
	end

	// Accumulate and offer on the last element when its key lies within [key_low, key_high]
	assign acc_sum = acc_q + DIST_W'(sq_s2);
	assign acc_v = v_s2 & last_s2 & (key_s2 >= key_low) & (key_s2 <= key_high);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (fin_s1) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= last_s2 ? '0 : acc_sum;
		end
	end

	always_comb begin
		push = acc_v | fin_s1;
		push_req.finish = fin_s1;
		push_req.sqdist = acc_sum;
		push_req.key = key_s2;
	end
endmodule
`default_nettype wire

FILE: src/rfks_queue.sv
// Short request queue between the front and back parts.
// Depends on rfks_pkg for req_t.
`default_nettype none
module rfks_queue
	import rfks_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire req_t push_req,
	output logic space,
	output logic pop_valid,
	output req_t pop_req,
	input  wire logic pop
);
	// Eight entries; front keeps three in flight so space means at least four free.
	localparam int DEPTH = 8;
	req_t mem [DEPTH];
	logic [2:0] wp_q, rp_q;
	logic [3:0] cnt_q;

	assign space = cnt_q <= 4'd4;
	assign pop_valid = cnt_q != 0;
	assign pop_req = mem[rp_q];

	always_ff @(posedge clk) if (push) mem[wp_q] <= push_req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + 4'(push) - 4'(pop);
		end
	end
endmodule
`default_nettype wire

FILE: src/rfks_back.sv
// Back part: top-K store, max search over cycles, replacement and sorted emission.
// Depends on rfks_pkg; pops requests from the queue and drives the result stream.
`default_nettype none
module rfks_back
	import rfks_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic pop_valid,
	input  wire req_t pop_req,
	output logic pop,
	input  wire logic [KCNT_W-1:0] eff_k,
	output logic out_valid,
	input  wire logic out_ready,
	output logic signed [KEY_W-1:0] result_key,
	output logic [DIST_W-1:0] result_distance,
	output logic result_valid,
	output logic is_last
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SCAN = 3'd1;
	localparam logic [2:0] ST_EMIT = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;

	logic [DIST_W-1:0] kd_q [K_MAX];
	logic signed [KEY_W-1:0] kk_q [K_MAX];
	logic [K_MAX-1:0] used_q;
	logic [KCNT_W-1:0] cnt_q;
	logic [2:0] st_q;
	logic [K_W-1:0] scan_q, max_q;
	logic found_q;
	req_t cur_q;
	logic above;

	// Pair compare of scanned slot against best so far
	assign above = !found_q || kd_q[scan_q] > kd_q[max_q] ||
		(kd_q[scan_q] == kd_q[max_q] && kk_q[scan_q] > kk_q[max_q]);

	assign pop = (st_q == ST_IDLE) & pop_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			used_q <= '0;
			scan_q <= '0;
			max_q <= '0;
			found_q <= 1'b0;
			out_valid <= 1'b0;
			cur_q <= '0;
			result_valid <= 1'b0;
			result_key <= '0;
			result_distance <= '0;
			is_last <= 1'b0;
			for (int i = 0; i < K_MAX; i++) begin
				kd_q[i] <= '0;
				kk_q[i] <= '0;
			end
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (pop_valid) begin
						cur_q <= pop_req;
						scan_q <= '0;
						found_q <= 1'b0;
						if (pop_req.finish) begin
							st_q <= ST_SCAN;
						end else if (cnt_q < eff_k) begin
							kd_q[cnt_q[K_W-1:0]] <= pop_req.sqdist;
							kk_q[cnt_q[K_W-1:0]] <= pop_req.key;
							used_q[cnt_q[K_W-1:0]] <= 1'b1;
							cnt_q <= cnt_q + 1'b1;
						end else if (cnt_q != 0) begin
							st_q <= ST_SCAN;
						end
					end
				end
				// One slot per cycle: find the maximum of used slots
				ST_SCAN: begin
					if (used_q[scan_q] && above) begin
						max_q <= scan_q;
						found_q <= 1'b1;
					end
					if (scan_q == K_W'(K_MAX - 1)) st_q <= ST_EMIT;
					else scan_q <= scan_q + 1'b1;
				end
				ST_EMIT: begin
					if (!cur_q.finish) begin
						if (cur_q.sqdist < kd_q[max_q]) begin
							kd_q[max_q] <= cur_q.sqdist;
							kk_q[max_q] <= cur_q.key;
						end
						st_q <= ST_IDLE;
					end else begin
						out_valid <= 1'b1;
						result_valid <= found_q;
						result_key <= found_q ? kk_q[max_q] : '0;
						result_distance <= found_q ? kd_q[max_q] : '0;
						is_last <= !found_q || ($countones(used_q) == 1);
						if (found_q) used_q[max_q] <= 1'b0;
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						scan_q <= '0;
						found_q <= 1'b0;
						if (is_last) begin
							cnt_q <= '0;
							used_q <= '0;
							st_q <= ST_IDLE;
						end else begin
							st_q <= ST_SCAN;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

FILE: src/range_filtered_knn_scan.sv
// Top level of the range-filtered k-nearest-neighbor scan.
// Depends on rfks_pkg, rfks_front, rfks_queue and rfks_back.
//
// channel  direction  payload
// s_axis   in         tdata: cmd[1:0], element_value[17:2], point_key[49:18]
// m_axis   out        tdata: result_key, result_distance; tuser: result_valid; tlast
// cfg      in         index[1:0], data[31:0]
//
// Elements enter one per cycle. A kept point is stored directly, or once the store
// is full, after a max search (one slot a cycle) finds the entry it may replace.
// Finish emits each result after a search over all slots. Reset clears all control
// state and the top-K store; the query store needs none. Input stalls while the
// queue holds over four requests; a finish also waits for the front pipeline.
`default_nettype none
module range_filtered_knn_scan
	import rfks_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [55:0] s_axis_tdata, // cmd, element_value, point_key, zero pad
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [79:0] m_axis_tdata, // result_key, result_distance, zero pad
	output logic m_axis_tuser, // result_valid
	output logic m_axis_tlast, // is_last
	input  wire logic cfg_valid,
	output logic cfg_ready,
	input  wire logic [1:0] cfg_index,
	input  wire logic [31:0] cfg_data
);
	logic signed [KEY_W-1:0] key_low_q, key_high_q;
	logic [4:0] ncount_q;
	logic [7:0] vlen_q;
	logic [DIM_W:0] eff_len;
	logic [KCNT_W-1:0] eff_k;
	logic push, space, pop_valid, pop;
	req_t push_req, pop_req;
	logic signed [KEY_W-1:0] rkey;
	logic [DIST_W-1:0] rdist;

	assign cfg_ready = 1'b1;
	// Config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_low_q <= '0;
			key_high_q <= 32'h7fffffff;
			ncount_q <= 5'd16;
			vlen_q <= 8'd128;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_KEY_LOW: key_low_q <= cfg_data;
				REG_KEY_HIGH: key_high_q <= cfg_data;
				REG_NCOUNT: ncount_q <= cfg_data[4:0];
				REG_VLEN: vlen_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign eff_len = (vlen_q == 0) ? (DIM_W+1)'(1) :
		(9'(vlen_q) > 9'(DIM_MAX)) ? (DIM_W+1)'(DIM_MAX) : (DIM_W+1)'(vlen_q);
	assign eff_k = (ncount_q == 0) ? KCNT_W'(1) :
		(6'(ncount_q) > 6'(K_MAX)) ? KCNT_W'(K_MAX) : KCNT_W'(ncount_q);

	rfks_front u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.cmd(s_axis_tdata[1:0]), .element_value(s_axis_tdata[17:2]),
		.point_key(s_axis_tdata[49:18]),
		.key_low(key_low_q), .key_high(key_high_q), .eff_len,
		.push, .push_req, .q_ready(space)
	);

	rfks_queue u_queue (
		.clk, .arst_n, .push, .push_req, .space, .pop_valid, .pop_req, .pop
	);

	rfks_back u_back (
		.clk, .arst_n, .pop_valid, .pop_req, .pop, .eff_k,
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.result_key(rkey), .result_distance(rdist),
		.result_valid(m_axis_tuser), .is_last(m_axis_tlast)
	);

	assign m_axis_tdata = {6'd0, rdist, rkey};
endmodule
`default_nettype wire

FILE: src/range_filtered_knn_scan_chk.sv
// Port-level checker for the k-nearest-neighbor scan, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none
module rfks_chk (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic m_axis_tuser,
	input wire logic m_axis_tlast,
	input wire logic [79:0] m_axis_tdata
);
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast) else $error("empty not last");
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 80'd0) else $error("empty data");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("hold");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[79:74] == 6'd0) else $error("pad");
endmodule

bind range_filtered_knn_scan rfks_chk u_chk (.*);
`default_nettype wire
